@@ rtl/fsfl_pkg.sv @@
// Shared types and constants of the fixed slot free list allocator.
// Holds the operation codes and the command and status structs that join
// the controller to the datapath. Depends on nothing.
`timescale 1ns / 1ps

package fsfl_pkg;

  localparam int NUM_SLOTS_DEF = 256;
  localparam int MAX_BATCH_DEF = 32;

  localparam int OP_W   = 2;
  localparam int SLOT_W = 8;
  localparam int LIM_W  = 6;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_BATCH = 2'd2,
    OP_CHAIN = 2'd3
  } op_e;

  typedef struct packed {
    logic init_wr;
    logic latch;
    logic set_fail;
    logic push;
    logic rd;
    logic pop;
    logic link;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic init_last;
    op_e  op;
    logic bad_free;
    logic lim_zero;
    logic empty;
    logic res_last;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/fsfl_ram.sv @@
// Generic single-write, single-read memory with a registered read port.
// Used for the link memory of the allocator. Depends on nothing.
`timescale 1ns / 1ps

module fsfl_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/fsfl_dp.sv @@
// Datapath of the allocator: head register, link memory, batch counters,
// the staged result and the output register. Depends on fsfl_pkg and
// fsfl_ram.
`timescale 1ns / 1ps

module fsfl_dp import fsfl_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int MAX_BATCH = MAX_BATCH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [SLOT_W-1:0] slot_index_i,
  input  logic [SLOT_W-1:0] chain_end_index_i,
  input  logic [LIM_W-1:0]  batch_limit_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [SLOT_W-1:0] granted_slot_o,
  output logic              ok_o,
  output logic              last_o,
  output logic [LIM_W-1:0]  batch_count_o,
  input  cmd_t              cmd_i,
  output sts_t              sts_o
);

  localparam int IDX_W  = $clog2(NUM_SLOTS);
  localparam int LINK_W = IDX_W + 1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LINK_W-1:0] link_t;

  localparam link_t LinkEnd = {1'b1, {IDX_W{1'b0}}};

  function automatic logic link_empty(input link_t v);
    return v[LINK_W-1] || (32'(v[IDX_W-1:0]) >= 32'(NUM_SLOTS));
  endfunction

  link_t             head_q, head_d;
  idx_t              init_q, init_d;
  op_e               op_q;
  logic [SLOT_W-1:0] first_q, endi_q;
  logic [LIM_W-1:0]  lim_q, cnt_q, cnt_d, lim_sat;
  idx_t              cur_q, prev_q;
  idx_t              res_slot_q;
  logic              res_ok_q, res_last_q;
  logic [LIM_W-1:0]  res_cnt_q;
  logic              out_valid_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic              out_ok_q, out_last_q;
  logic [LIM_W-1:0]  out_cnt_q;

  logic  we;
  idx_t  waddr;
  link_t wdata;
  link_t rdata;
  logic  out_free;

  assign lim_sat = (32'(batch_limit_i) > 32'(MAX_BATCH)) ? LIM_W'(MAX_BATCH) : batch_limit_i;
  assign cnt_d   = cnt_q + LIM_W'(1);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    priority if (cmd_i.init_wr) begin
      we    = 1'b1;
      waddr = init_q;
      wdata = (init_q == '0) ? LinkEnd : {1'b0, init_q - idx_t'(1)};
    end else if (cmd_i.push) begin
      we    = 1'b1;
      waddr = (op_q == OP_CHAIN) ? IDX_W'(endi_q) : IDX_W'(first_q);
      wdata = head_q;
    end else if (cmd_i.pop && op_q == OP_BATCH) begin
      we    = 1'b1;
      waddr = head_q[IDX_W-1:0];
      wdata = LinkEnd;
    end else if (cmd_i.link && cnt_q > LIM_W'(1)) begin
      we    = 1'b1;
      waddr = prev_q;
      wdata = {1'b0, cur_q};
    end
  end

  fsfl_ram #(
    .WIDTH(LINK_W),
    .DEPTH(NUM_SLOTS)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd),
    .raddr_i(head_q[IDX_W-1:0]),
    .rdata_o(rdata)
  );

  always_comb begin
    head_d = head_q;
    init_d = init_q;
    if (cmd_i.init_wr) begin
      init_d = init_q + idx_t'(1);
    end
    if (cmd_i.push) begin
      head_d = {1'b0, IDX_W'(first_q)};
    end else if (cmd_i.pop) begin
      head_d = rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= {1'b0, IDX_W'(NUM_SLOTS - 1)};
      init_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q <= head_d;
      init_q <= init_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q    <= op_e'(operation_i);
      first_q <= slot_index_i;
      endi_q  <= chain_end_index_i;
      lim_q   <= lim_sat;
      cnt_q   <= '0;
    end
    if (cmd_i.set_fail) begin
      res_slot_q <= '0;
      res_ok_q   <= 1'b0;
      res_last_q <= 1'b1;
      res_cnt_q  <= '0;
    end
    if (cmd_i.push) begin
      res_slot_q <= '0;
      res_ok_q   <= 1'b1;
      res_last_q <= 1'b1;
      res_cnt_q  <= '0;
    end
    if (cmd_i.pop) begin
      cur_q      <= head_q[IDX_W-1:0];
      cnt_q      <= cnt_d;
      res_slot_q <= head_q[IDX_W-1:0];
      res_ok_q   <= 1'b1;
      res_last_q <= (op_q != OP_BATCH) || (cnt_d == lim_q) || link_empty(rdata);
      res_cnt_q  <= cnt_d;
    end
    if (cmd_i.link) begin
      prev_q <= cur_q;
    end
    if (cmd_i.emit) begin
      out_slot_q <= SLOT_W'(res_slot_q);
      out_ok_q   <= res_ok_q;
      out_last_q <= res_last_q;
      out_cnt_q  <= res_cnt_q;
    end
  end

  always_comb begin
    sts_o.init_last = (32'(init_q) == 32'(NUM_SLOTS - 1));
    sts_o.op        = op_q;
    sts_o.bad_free  = (32'(first_q) >= 32'(NUM_SLOTS)) ||
                      ((op_q == OP_CHAIN) && (32'(endi_q) >= 32'(NUM_SLOTS)));
    sts_o.lim_zero  = (lim_q == '0);
    sts_o.empty     = link_empty(head_q);
    sts_o.res_last  = res_last_q;
    sts_o.out_free  = out_free;
  end

  assign out_valid_o    = out_valid_q;
  assign granted_slot_o = out_slot_q;
  assign ok_o           = out_ok_q;
  assign last_o         = out_last_q;
  assign batch_count_o  = out_cnt_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result register overwritten while a beat is pending");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.init_wr, cmd_i.push, cmd_i.pop, cmd_i.link}))
    else $error("two link memory writers in one cycle");

  a_batch_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pop && op_q == OP_BATCH) |-> (cnt_q < lim_q))
    else $error("batch granted beyond its limit");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ok_q) |-> (out_slot_q == '0 && out_cnt_q == '0 && out_last_q))
    else $error("failed result carries a slot or count");

endmodule

@@ rtl/fsfl_ctrl.sv @@
// Controller of the allocator: sequences initialization, decode, pops,
// chain linking and result beats. Depends on fsfl_pkg.
`timescale 1ns / 1ps

module fsfl_ctrl import fsfl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  typedef enum logic [5:0] {
    ST_INIT   = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_DECODE = 6'b000100,
    ST_POP    = 6'b001000,
    ST_LINK   = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (sts_i.init_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts_i.op)
          OP_ALLOC: begin
            if (sts_i.empty) begin
              cmd_o.set_fail = 1'b1;
              state_d        = ST_EMIT;
            end else begin
              cmd_o.rd = 1'b1;
              state_d  = ST_POP;
            end
          end
          OP_BATCH: begin
            if (sts_i.empty || sts_i.lim_zero) begin
              cmd_o.set_fail = 1'b1;
              state_d        = ST_EMIT;
            end else begin
              cmd_o.rd = 1'b1;
              state_d  = ST_POP;
            end
          end
          OP_FREE, OP_CHAIN: begin
            if (sts_i.bad_free) begin
              cmd_o.set_fail = 1'b1;
            end else begin
              cmd_o.push = 1'b1;
            end
            state_d = ST_EMIT;
          end
          default: state_d = ST_EMIT;
        endcase
      end
      ST_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = (sts_i.op == OP_BATCH) ? ST_LINK : ST_EMIT;
      end
      ST_LINK: begin
        cmd_o.link = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.res_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.rd = 1'b1;
            state_d  = ST_POP;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  a_cont_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && !sts_i.res_last) |=> (state_q == ST_POP))
    else $error("batch did not continue after a non-final beat");

  a_rd_then_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd |=> cmd_o.pop)
    else $error("link read not consumed in the following cycle");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item accepted before the first finished");

endmodule

@@ rtl/fixed_slot_free_list_allocator.sv @@
// Top level of the fixed slot free list allocator.
// Depends on fsfl_pkg, fsfl_ctrl, fsfl_dp and fsfl_ram.
//
// The block hands out and takes back slots of a fixed pool kept as a LIFO
// free list in a link memory. An input beat carries an operation: allocate
// one slot, free one slot, allocate a batch, or free a whole chain. Every
// operation answers with one result beat, except a batch that grants slots,
// which answers with one beat per granted slot and marks the final one.
// Items are handled one at a time. Each pop waits for the registered read
// of the link memory, and each granted batch slot costs a pop, a link step
// and a result beat; the pop and the link step share the single write port.
// After reset the block writes the initial link of every slot into the link
// memory, with in_ready_o low; then every slot is free and the highest slot
// sits at the head of the list.
// The result register lets an item be accepted while the previous result
// beat is still waiting. When the receiver stalls, the block holds its
// pending result and stops before loading the next one.
`timescale 1ns / 1ps

module fixed_slot_free_list_allocator import fsfl_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int MAX_BATCH = MAX_BATCH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [SLOT_W-1:0] slot_index_i,
  input  logic [SLOT_W-1:0] chain_end_index_i,
  input  logic [LIM_W-1:0]  batch_limit_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [SLOT_W-1:0] granted_slot_o,
  output logic              ok_o,
  output logic              last_o,
  output logic [LIM_W-1:0]  batch_count_o
);

  cmd_t cmd;
  sts_t sts;

  fsfl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  fsfl_dp #(
    .NUM_SLOTS(NUM_SLOTS),
    .MAX_BATCH(MAX_BATCH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .operation_i      (operation_i),
    .slot_index_i     (slot_index_i),
    .chain_end_index_i(chain_end_index_i),
    .batch_limit_i    (batch_limit_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .granted_slot_o   (granted_slot_o),
    .ok_o             (ok_o),
    .last_o           (last_o),
    .batch_count_o    (batch_count_o),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for fixed_slot_free_list_allocator.
// Keeps its own copy of the free list and link memory, predicts every result
// beat and compares it field by field. Depends on fsfl_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import fsfl_pkg::*;

  localparam int RANDOM_ITEMS = 130;
  localparam int CALM_ITEMS   = 30;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              ok;
    logic              last;
    logic [LIM_W-1:0]  count;
  } grant_t;

  typedef struct packed {
    logic [SLOT_W-1:0] first;
    logic [SLOT_W-1:0] tail;
  } chain_t;

  class slot_pool_model;
    localparam logic [SLOT_W:0] END_MARK = 9'h100;

    logic [SLOT_W:0]   links [NUM_SLOTS_DEF];
    logic [SLOT_W:0]   head;
    grant_t            expected_grants [$];
    logic [SLOT_W-1:0] held_slots [$];
    chain_t            held_chains [$];
    int                errors;

    function new();
      links[0] = END_MARK;
      for (int i = 1; i < NUM_SLOTS_DEF; i++) links[i] = 9'(i - 1);
      head   = 9'(NUM_SLOTS_DEF - 1);
      errors = 0;
    endfunction

    function bit list_empty();
      return head[SLOT_W] == 1'b1 || int'(head) >= NUM_SLOTS_DEF;
    endfunction

    function void expect_grant(logic [SLOT_W-1:0] slot, logic ok, logic last,
                               logic [LIM_W-1:0] count);
      grant_t g;
      g.slot  = slot;
      g.ok    = ok;
      g.last  = last;
      g.count = count;
      expected_grants.insert(expected_grants.size(), g);
    endfunction

    function void note_request(op_e op, logic [SLOT_W-1:0] slot,
                               logic [SLOT_W-1:0] tail, logic [LIM_W-1:0] limit);
      int              lim;
      int              n;
      logic [SLOT_W:0] s;
      logic [SLOT_W:0] prev;
      chain_t          c;
      case (op)
        OP_ALLOC: begin
          if (list_empty()) begin
            expect_grant('0, 1'b0, 1'b1, '0);
          end else begin
            s    = head;
            head = links[s[SLOT_W-1:0]];
            expect_grant(s[SLOT_W-1:0], 1'b1, 1'b1, 6'd1);
            held_slots.insert(held_slots.size(), s[SLOT_W-1:0]);
          end
        end
        OP_FREE: begin
          if (int'(slot) >= NUM_SLOTS_DEF) begin
            expect_grant('0, 1'b0, 1'b1, '0);
          end else begin
            links[slot] = head;
            head        = {1'b0, slot};
            expect_grant('0, 1'b1, 1'b1, '0);
          end
        end
        OP_CHAIN: begin
          if (int'(slot) >= NUM_SLOTS_DEF || int'(tail) >= NUM_SLOTS_DEF) begin
            expect_grant('0, 1'b0, 1'b1, '0);
          end else begin
            links[tail] = head;
            head        = {1'b0, slot};
            expect_grant('0, 1'b1, 1'b1, '0);
          end
        end
        default: begin
          lim  = (int'(limit) > MAX_BATCH_DEF) ? MAX_BATCH_DEF : int'(limit);
          n    = 0;
          prev = '0;
          while (n < lim && !list_empty()) begin
            s    = head;
            head = links[s[SLOT_W-1:0]];
            links[s[SLOT_W-1:0]] = END_MARK;
            if (n > 0) links[prev[SLOT_W-1:0]] = s;
            else c.first = s[SLOT_W-1:0];
            prev = s;
            n++;
            expect_grant(s[SLOT_W-1:0], 1'b1, (n == lim) || list_empty(), 6'(n));
          end
          if (n == 0) begin
            expect_grant('0, 1'b0, 1'b1, '0);
          end else begin
            c.tail = prev[SLOT_W-1:0];
            held_chains.insert(held_chains.size(), c);
          end
        end
      endcase
    endfunction

    function void check_grant(logic [SLOT_W-1:0] slot, logic ok, logic last,
                              logic [LIM_W-1:0] count);
      grant_t want;
      if (expected_grants.size() == 0) begin
        $error("result beat with nothing expected: slot %0d ok %0d last %0d count %0d",
               slot, ok, last, count);
        errors++;
        return;
      end
      want = expected_grants.pop_front();
      if (slot !== want.slot) begin
        $error("granted_slot: expected %0d, got %0d", want.slot, slot);
        errors++;
      end
      if (ok !== want.ok) begin
        $error("ok: expected %0d, got %0d", want.ok, ok);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, last);
        errors++;
      end
      if (count !== want.count) begin
        $error("batch_count: expected %0d, got %0d", want.count, count);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i             = 1'b0;
  logic              rst_ni            = 1'b0;
  logic              in_valid_i        = 1'b0;
  logic              in_ready_o;
  logic [OP_W-1:0]   operation_i       = '0;
  logic [SLOT_W-1:0] slot_index_i      = '0;
  logic [SLOT_W-1:0] chain_end_index_i = '0;
  logic [LIM_W-1:0]  batch_limit_i     = '0;
  logic              out_valid_o;
  logic              out_ready_i       = 1'b0;
  logic [SLOT_W-1:0] granted_slot_o;
  logic              ok_o;
  logic              last_o;
  logic [LIM_W-1:0]  batch_count_o;

  slot_pool_model pool;
  bit             calm        = 1'b0;
  int             stall_left  = 0;
  int             steady_left = 0;
  int             cycles      = 0;

  fixed_slot_free_list_allocator i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .operation_i       (operation_i),
    .slot_index_i      (slot_index_i),
    .chain_end_index_i (chain_end_index_i),
    .batch_limit_i     (batch_limit_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .granted_slot_o    (granted_slot_o),
    .ok_o              (ok_o),
    .last_o            (last_o),
    .batch_count_o     (batch_count_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= (stall_left == 1);
    end else if (steady_left != 0) begin
      steady_left <= steady_left - 1;
      out_ready_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(1, 12);
      out_ready_i <= 1'b0;
    end else begin
      if (!calm && $urandom_range(0, 15) == 0) steady_left <= $urandom_range(20, 60);
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      pool.check_grant(granted_slot_o, ok_o, last_o, batch_count_o);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic send_request(op_e op, logic [SLOT_W-1:0] slot,
                              logic [SLOT_W-1:0] tail, logic [LIM_W-1:0] limit);
    in_valid_i        <= 1'b1;
    operation_i       <= op;
    slot_index_i      <= slot;
    chain_end_index_i <= tail;
    batch_limit_i     <= limit;
    do @(posedge clk_i); while (!in_ready_o);
    pool.note_request(op, slot, tail, limit);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  function automatic logic [SLOT_W-1:0] any_slot();
    return SLOT_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [LIM_W-1:0] any_limit();
    return LIM_W'($urandom_range(0, 63));
  endfunction

  initial begin
    chain_t            c;
    logic [SLOT_W-1:0] s;
    int                k;
    int                r;
    pool = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_request(OP_ALLOC, 8'hFF, 8'hFF, 6'h3F);
    send_request(OP_ALLOC, 8'h00, 8'h00, 6'h00);
    s = pool.held_slots.pop_front();
    send_request(OP_FREE, s, 8'h00, 6'h00);
    send_request(OP_BATCH, 8'h00, 8'h00, 6'd0);
    send_request(OP_BATCH, 8'hFF, 8'hFF, 6'd1);
    send_request(OP_BATCH, 8'h00, 8'h00, 6'h3F);
    c = pool.held_chains.pop_back();
    send_request(OP_CHAIN, c.first, c.tail, 6'd0);
    while (!pool.list_empty()) send_request(OP_BATCH, any_slot(), any_slot(), 6'd32);
    send_request(OP_ALLOC, any_slot(), any_slot(), any_limit());
    send_request(OP_BATCH, any_slot(), any_slot(), 6'd40);
    c = pool.held_chains.pop_front();
    send_request(OP_CHAIN, c.first, c.tail, any_limit());
    s = pool.held_slots.pop_front();
    send_request(OP_FREE, s, any_slot(), any_limit());
    send_request(OP_FREE, s, any_slot(), any_limit());
    send_request(OP_CHAIN, any_slot(), any_slot(), any_limit());

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if (n == RANDOM_ITEMS / 3) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (pool.expected_grants.size() != 0);
      end
      r = $urandom_range(0, 99);
      if (r < 15) begin
        case ($urandom_range(0, 2))
          0:       send_request(OP_FREE, any_slot(), any_slot(), any_limit());
          1:       send_request(OP_CHAIN, any_slot(), any_slot(), any_limit());
          default: send_request(OP_BATCH, any_slot(), any_slot(), any_limit());
        endcase
      end else if (r < 40) begin
        send_request(OP_ALLOC, any_slot(), any_slot(), any_limit());
      end else if (r < 60 && pool.held_slots.size() != 0) begin
        k = $urandom_range(0, pool.held_slots.size() - 1);
        s = pool.held_slots[k];
        pool.held_slots.delete(k);
        send_request(OP_FREE, s, any_slot(), any_limit());
      end else if (r >= 80 && pool.held_chains.size() != 0) begin
        k = $urandom_range(0, pool.held_chains.size() - 1);
        c = pool.held_chains[k];
        pool.held_chains.delete(k);
        send_request(OP_CHAIN, c.first, c.tail, any_limit());
      end else if ($urandom_range(0, 4) == 0) begin
        send_request(OP_BATCH, any_slot(), any_slot(), any_limit());
      end else begin
        send_request(OP_BATCH, any_slot(), any_slot(), LIM_W'($urandom_range(1, 8)));
      end
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pool.expected_grants.size() != 0);
    repeat (20) @(posedge clk_i);
    if (pool.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/fsfl_pkg.sv
rtl/fsfl_ram.sv
rtl/fsfl_dp.sv
rtl/fsfl_ctrl.sv
rtl/fixed_slot_free_list_allocator.sv
sim/tb.sv
